// ===== rtl/crcfs_pkg.sv =====
package crcfs_pkg;

    localparam int PREAMBLE_BITS = 25;
    localparam int TAIL_ONES     = 5;

    localparam int LEN_W   = 13;
    localparam int FIELD_W = 16;
    localparam int BYTE_W  = 8;

    // counter spans the longest phase: preamble or a 16-bit field
    localparam int CNT_W = (PREAMBLE_BITS > FIELD_W) ? $clog2(PREAMBLE_BITS) : $clog2(FIELD_W);

    localparam logic [FIELD_W-1:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic                 first;      // preamble and length go ahead of the byte
        logic                 crc_only;   // closing step of a one-byte frame
        logic                 crc_after;  // byte ends the frame, CRC follows it
        logic [BYTE_W-1:0]    data;
        logic [FIELD_W-1:0]   length;
    } job_t;

    function automatic logic pre_bit(input logic [CNT_W-1:0] idx);
        logic b;
        if (int'(idx) + TAIL_ONES >= PREAMBLE_BITS)
        begin
            b = 1'b1;
        end
        else
        begin
            b = ~idx[0];
        end
        return b;
    endfunction

    function automatic logic [FIELD_W-1:0] crc_step(input logic [FIELD_W-1:0] crc,
                                                    input logic               b);
        logic fb;
        fb = crc[FIELD_W-1] ^ b;
        return {crc[FIELD_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    endfunction

endpackage

// ===== rtl/crcfs_front.sv =====
module crcfs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [crcfs_pkg::LEN_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [crcfs_pkg::BYTE_W-1:0]  data_byte,
    input  logic                          q_full,
    output logic                          push,
    output crcfs_pkg::job_t               push_job
);

    logic [crcfs_pkg::LEN_W-1:0] msg_bytes_reg;
    logic [crcfs_pkg::LEN_W-1:0] taken_reg;
    logic [crcfs_pkg::LEN_W-1:0] taken_next;
    logic                        pending_reg;
    logic                        pending_next;

    logic [crcfs_pkg::LEN_W-1:0] eff;
    logic [crcfs_pkg::LEN_W-1:0] taken_inc;
    logic                        first;
    logic                        frame_done;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // zero length acts as a one-byte frame
    assign eff        = (msg_bytes_reg == '0) ? crcfs_pkg::LEN_W'(1) : msg_bytes_reg;
    assign first      = (taken_reg == '0);
    assign taken_inc  = taken_reg + crcfs_pkg::LEN_W'(1);
    assign frame_done = (taken_inc >= eff) || (taken_inc == '0);

    always_comb
    begin
        taken_next   = taken_reg;
        pending_next = pending_reg;

        push_job.first     = 1'b0;
        push_job.crc_only  = 1'b0;
        push_job.crc_after = 1'b0;
        push_job.data      = data_byte;
        push_job.length    = {eff, 3'b000};

        if (pending_reg)
        begin
            push_job.crc_only = 1'b1;
            if (push)
            begin
                pending_next = 1'b0;
                taken_next   = '0;
            end
        end
        else
        begin
            push_job.first     = first;
            push_job.crc_after = frame_done && !first;
            if (push)
            begin
                if (frame_done && !first)
                begin
                    taken_next = '0;
                end
                else
                begin
                    taken_next = taken_inc;
                end
                // a one-byte frame owes its CRC to the next word
                if (frame_done && first)
                begin
                    pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_bytes_reg <= crcfs_pkg::LEN_W'(1);
            taken_reg     <= '0;
            pending_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                msg_bytes_reg <= cfg_data;
            end
            taken_reg   <= taken_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ===== rtl/crcfs_queue.sv =====
module crcfs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crcfs_pkg::job_t  push_job,
    input  logic             pop,
    output crcfs_pkg::job_t  head_job,
    output logic             full,
    output logic             empty
);

    crcfs_pkg::job_t slot_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== rtl/crcfs_back.sv =====
module crcfs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  crcfs_pkg::job_t  head_job,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             tx_bit,
    output logic             frame_end
);

    typedef enum logic [1:0] {
        PH_PRE,
        PH_LEN,
        PH_DATA,
        PH_CRC
    } phase_t;

    localparam logic [crcfs_pkg::CNT_W-1:0] PRE_LAST  =
        crcfs_pkg::CNT_W'(crcfs_pkg::PREAMBLE_BITS - 1);
    localparam logic [crcfs_pkg::CNT_W-1:0] FLD_LAST  =
        crcfs_pkg::CNT_W'(crcfs_pkg::FIELD_W - 1);
    localparam logic [crcfs_pkg::CNT_W-1:0] BYTE_LAST =
        crcfs_pkg::CNT_W'(crcfs_pkg::BYTE_W - 1);

    phase_t                            phase_reg, phase_next;
    logic                              busy_reg, busy_next;
    logic [crcfs_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic [crcfs_pkg::FIELD_W-1:0]     sh_reg, sh_next;
    logic [crcfs_pkg::FIELD_W-1:0]     crc_reg, crc_next;
    crcfs_pkg::job_t                   job_reg, job_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              tx_bit_reg, tx_bit_next;
    logic                              frame_end_reg, frame_end_next;

    logic advance;
    logic fire;
    logic cur_bit;
    logic last;
    logic job_done;

    assign out_valid = out_valid_reg;
    assign tx_bit    = tx_bit_reg;
    assign frame_end = frame_end_reg;

    // output register frees up when empty or taken this cycle
    assign advance = !out_valid_reg || !out_stall;
    assign fire    = busy_reg && advance;

    always_comb
    begin
        case (phase_reg)
            PH_PRE:
            begin
                cur_bit = crcfs_pkg::pre_bit(cnt_reg);
                last    = (cnt_reg == PRE_LAST);
            end
            PH_LEN:
            begin
                cur_bit = sh_reg[crcfs_pkg::FIELD_W-1];
                last    = (cnt_reg == FLD_LAST);
            end
            PH_DATA:
            begin
                cur_bit = sh_reg[crcfs_pkg::FIELD_W-1];
                last    = (cnt_reg == BYTE_LAST);
            end
            PH_CRC:
            begin
                cur_bit = crc_reg[crcfs_pkg::FIELD_W-1];
                last    = (cnt_reg == FLD_LAST);
            end
            default:
            begin
                cur_bit = 1'b0;
                last    = 1'b1;
            end
        endcase
    end

    assign job_done = fire && last &&
                      ((phase_reg == PH_CRC) || ((phase_reg == PH_DATA) && !job_reg.crc_after));
    assign pop      = !q_empty && (!busy_reg || job_done);

    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        sh_next        = sh_reg;
        crc_next       = crc_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg;
        tx_bit_next    = tx_bit_reg;
        frame_end_next = frame_end_reg;

        if (advance)
        begin
            out_valid_next = fire;
            tx_bit_next    = cur_bit;
            frame_end_next = fire && last && (phase_reg == PH_CRC);
        end

        if (fire)
        begin
            cnt_next = cnt_reg + crcfs_pkg::CNT_W'(1);
            case (phase_reg)
                PH_LEN, PH_DATA:
                begin
                    // hold the length through the preamble, advance only while sending it
                    sh_next  = {sh_reg[crcfs_pkg::FIELD_W-2:0], 1'b0};
                    crc_next = crcfs_pkg::crc_step(crc_reg, cur_bit);
                end
                PH_CRC:
                begin
                    // shifting out leaves the register cleared for the next frame
                    crc_next = {crc_reg[crcfs_pkg::FIELD_W-2:0], 1'b0};
                end
                default:
                begin
                    crc_next = crc_reg;
                end
            endcase

            if (last)
            begin
                cnt_next = '0;
                case (phase_reg)
                    PH_PRE:
                    begin
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        phase_next = PH_DATA;
                        sh_next    = {job_reg.data, {crcfs_pkg::BYTE_W{1'b0}}};
                    end
                    PH_DATA:
                    begin
                        phase_next = PH_CRC;
                    end
                    default:
                    begin
                        phase_next = PH_CRC;
                    end
                endcase
            end
        end

        if (job_done)
        begin
            busy_next = 1'b0;
        end

        if (pop)
        begin
            busy_next = 1'b1;
            job_next  = head_job;
            cnt_next  = '0;
            if (head_job.crc_only)
            begin
                phase_next = PH_CRC;
            end
            else if (head_job.first)
            begin
                phase_next = PH_PRE;
                sh_next    = head_job.length;
                crc_next   = '0;
            end
            else
            begin
                phase_next = PH_DATA;
                sh_next    = {head_job.data, {crcfs_pkg::BYTE_W{1'b0}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PRE;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            sh_reg        <= '0;
            crc_reg       <= '0;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
            tx_bit_reg    <= 1'b0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            sh_reg        <= sh_next;
            crc_reg       <= crc_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
            tx_bit_reg    <= tx_bit_next;
            frame_end_reg <= frame_end_next;
        end
    end

endmodule

// ===== rtl/crc_framed_serial_transmitter.sv =====
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-------------------------
// in      | input     | in_valid / in_stall   | data_byte[7:0]
// out     | output    | out_valid / out_stall | tx_bit, frame_end
// cfg     | input     | cfg_we (no wait)      | cfg_data[12:0] = message_bytes
//
// One serial bit leaves per cycle from the bit serializer while it is busy and the
// output is not stalled. The first byte of a frame follows the preamble and length,
// the last precedes the CRC. A one-byte frame's CRC goes out on the next word.
// A two-deep word queue lets bytes be taken while the serializer is busy.
// Reset clears the frame state and sets message_bytes to 1.
// A stall on the output holds the current bit; the input stalls once the queue fills.
module crc_framed_serial_transmitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [crcfs_pkg::LEN_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [crcfs_pkg::BYTE_W-1:0]  data_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          tx_bit,
    output logic                          frame_end
);

    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;
    crcfs_pkg::job_t push_job;
    crcfs_pkg::job_t head_job;

    crcfs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    crcfs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (q_full),
        .empty    (q_empty)
    );

    crcfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_job  (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tx_bit    (tx_bit),
        .frame_end (frame_end)
    );

endmodule

// ===== rtl/crcfs_checker.sv =====
module crcfs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic                          tx_bit,
    input logic                          frame_end
);

    // a stalled word stays offered
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("out_valid dropped under stall");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(tx_bit) && $stable(frame_end))
        else $error("output payload changed under stall");

    // the word after a frame's last CRC bit opens the next preamble with a one
    a_preamble_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && frame_end |=> !out_valid || tx_bit)
        else $error("new frame does not start with preamble bit one");

    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

endmodule

bind crc_framed_serial_transmitter crcfs_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .tx_bit    (tx_bit),
    .frame_end (frame_end)
);
